// ===== design/sts_pkg.sv =====
// Shared types, widths and constants for the solar tracker servo stepper.
// No dependencies; imported by sts_axis_step and solar_tracker_servo_stepper.
package sts_pkg;

	localparam int unsigned SAMPLE_BITS              = 12;
	localparam int unsigned MARGIN_W                 = 12;
	localparam int unsigned STEP_W                   = 8;
	localparam int unsigned PULSE_W                  = 15;
	localparam int unsigned CFG_DATA_W               = 15;
	localparam int unsigned MARGIN_FRAC_BITS_DEFAULT = 12;

	localparam logic [MARGIN_W-1:0] MARGIN_RESET    = 12'd328;
	localparam logic [STEP_W-1:0]   STEP_RESET      = 8'd7;
	localparam logic [PULSE_W-1:0]  PULSE_MIN_RESET = 15'd500;
	localparam logic [PULSE_W-1:0]  PULSE_MAX_RESET = 15'd1900;
	localparam logic [PULSE_W-1:0]  PULSE_RESET     = 15'd500;

	typedef enum logic [1:0] {
		CFG_MARGIN    = 2'd0,
		CFG_STEP      = 2'd1,
		CFG_PULSE_MIN = 2'd2,
		CFG_PULSE_MAX = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] top_right;
		logic [SAMPLE_BITS-1:0] top_left;
		logic [SAMPLE_BITS-1:0] bottom_left;
		logic [SAMPLE_BITS-1:0] bottom_right;
	} sample_t;

	typedef struct packed {
		logic [PULSE_W-1:0] horizontal_pulse_us;
		logic [PULSE_W-1:0] vertical_pulse_us;
		logic               aligned;
	} result_t;

	// Step request for one axis; at most one of the two is set.
	typedef struct packed {
		logic up;
		logic down;
	} axis_cmd_t;

endpackage

// ===== design/sts_axis_step.sv =====
// One servo axis: step the pulse width up or down, then clamp it.
// Depends on sts_pkg for widths and the axis_cmd_t request struct.
module sts_axis_step (
	input  logic [sts_pkg::PULSE_W-1:0] pulse,
	input  logic [sts_pkg::STEP_W-1:0]  step,
	input  sts_pkg::axis_cmd_t          cmd,
	input  logic [sts_pkg::PULSE_W-1:0] pulse_min,
	input  logic [sts_pkg::PULSE_W-1:0] pulse_max,
	output logic [sts_pkg::PULSE_W-1:0] pulse_next
);
	import sts_pkg::*;

	localparam int unsigned SUM_W = PULSE_W + 2;

	logic signed [SUM_W-1:0] base;
	logic signed [SUM_W-1:0] delta;
	logic signed [SUM_W-1:0] stepped;
	logic signed [SUM_W-1:0] lim_min;
	logic signed [SUM_W-1:0] lim_max;
	logic signed [SUM_W-1:0] capped;
	logic signed [SUM_W-1:0] clamped;

	assign base    = signed'({2'b00, pulse});
	assign delta   = signed'({{(SUM_W-STEP_W){1'b0}}, step});
	assign lim_min = signed'({2'b00, pulse_min});
	assign lim_max = signed'({2'b00, pulse_max});

	always_comb begin
		if (cmd.up) begin
			stepped = base + delta;
		end else if (cmd.down) begin
			stepped = base - delta;
		end else begin
			stepped = base;
		end
	end

	// Maximum first, then minimum: a minimum above the maximum wins.
	assign capped  = (stepped > lim_max) ? lim_max : stepped;
	assign clamped = (capped < lim_min) ? lim_min : capped;

	assign pulse_next = clamped[PULSE_W-1:0];

endmodule

// ===== design/solar_tracker_servo_stepper.sv =====
// Path: a sample word goes to stage 1, then stage 2, then the result register.
// Throughput: one sample word per cycle unless output stalls; the per-word loop on
// pulse and flag state closes in the last stage, so consecutive words never wait on
// each other. Each stage advances on its own when its successor is empty or moving.
// Reset: asynchronous, active low; registers return to margin 328, step 7 us,
// limits 500..1900 us, both pulses 500 us, both reached flags clear, pipeline empty.
module solar_tracker_servo_stepper #(
	parameter int unsigned MARGIN_FRAC_BITS = sts_pkg::MARGIN_FRAC_BITS_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           sample_valid,
	output logic                           sample_ready,
	input  sts_pkg::sample_t               sample,

	output logic                           result_valid,
	input  logic                           result_ready,
	output sts_pkg::result_t               result,

	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  sts_pkg::cfg_reg_t              cfg_index,
	input  logic [sts_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sts_pkg::*;

	localparam int unsigned SUM_W  = SAMPLE_BITS + 1;
	localparam int unsigned PROD_W = MARGIN_W + SUM_W;
	// Wide enough for both |diff| << F and margin * pair sum.
	localparam int unsigned CMP_W  = SAMPLE_BITS + 1 +
		((MARGIN_FRAC_BITS > MARGIN_W) ? MARGIN_FRAC_BITS : MARGIN_W);

	// ------------------------------------------------------------------
	// Configuration registers. The port never stalls.
	// ------------------------------------------------------------------
	logic [MARGIN_W-1:0] margin_q;
	logic [STEP_W-1:0]   step_q;
	logic [PULSE_W-1:0]  pulse_min_q;
	logic [PULSE_W-1:0]  pulse_max_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q    <= MARGIN_RESET;
			step_q      <= STEP_RESET;
			pulse_min_q <= PULSE_MIN_RESET;
			pulse_max_q <= PULSE_MAX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MARGIN:    margin_q    <= cfg_data[MARGIN_W-1:0];
				CFG_STEP:      step_q      <= cfg_data[STEP_W-1:0];
				CFG_PULSE_MIN: pulse_min_q <= cfg_data[PULSE_W-1:0];
				CFG_PULSE_MAX: pulse_max_q <= cfg_data[PULSE_W-1:0];
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshake: each stage loads when it is empty or its word moves on.
	// ------------------------------------------------------------------
	logic valid_s1;
	logic valid_s2;
	logic result_valid_q;
	logic en_s1;
	logic en_s2;
	logic en_out;

	assign en_out       = !result_valid_q || result_ready;
	assign en_s2        = !valid_s2 || en_out;
	assign en_s1        = !valid_s1 || en_s2;
	assign sample_ready = en_s1;

	// ------------------------------------------------------------------
	// Stage 1: capture the four samples.
	// ------------------------------------------------------------------
	sample_t sample_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && sample_valid) begin
			sample_s1 <= sample;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1 -> 2: pair sums, margin products, pair differences.
	// The band test  s*2*2^F > (2^F-m)*p  and  s*2*2^F < (2^F+m)*p  is
	// the same as  |2s - p| * 2^F < m*p . For a pair, 2s - p is the
	// difference of its two samples, so one test covers both members.
	// A dark pair (p = 0) fails, since 0 < 0 is false.
	// ------------------------------------------------------------------
	logic [SAMPLE_BITS-1:0] tl, tr, bl, br;
	logic [SUM_W-1:0]       sum_top, sum_bot, sum_left, sum_right;
	logic [SAMPLE_BITS-1:0] absd_top, absd_bot, absd_left, absd_right;
	logic [PROD_W-1:0]      prod_top, prod_bot, prod_left, prod_right;
	logic                   v_inc, v_dec, h_inc, h_dec;

	assign tl = sample_s1.top_left;
	assign tr = sample_s1.top_right;
	assign bl = sample_s1.bottom_left;
	assign br = sample_s1.bottom_right;

	assign sum_top   = {1'b0, tl} + {1'b0, tr};
	assign sum_bot   = {1'b0, bl} + {1'b0, br};
	assign sum_left  = {1'b0, tl} + {1'b0, bl};
	assign sum_right = {1'b0, tr} + {1'b0, br};

	assign absd_top   = (tl >= tr) ? (tl - tr) : (tr - tl);
	assign absd_bot   = (bl >= br) ? (bl - br) : (br - bl);
	assign absd_left  = (tl >= bl) ? (tl - bl) : (bl - tl);
	assign absd_right = (tr >= br) ? (tr - br) : (br - tr);

	assign prod_top   = {{SUM_W{1'b0}}, margin_q} * {{MARGIN_W{1'b0}}, sum_top};
	assign prod_bot   = {{SUM_W{1'b0}}, margin_q} * {{MARGIN_W{1'b0}}, sum_bot};
	assign prod_left  = {{SUM_W{1'b0}}, margin_q} * {{MARGIN_W{1'b0}}, sum_left};
	assign prod_right = {{SUM_W{1'b0}}, margin_q} * {{MARGIN_W{1'b0}}, sum_right};

	// Step direction: left brighter lowers vertical, top brighter raises horizontal.
	assign v_dec = (tl > tr) && (bl > br);
	assign v_inc = (tl < tr) && (bl < br);
	assign h_inc = (tl > bl) && (tr > br);
	assign h_dec = (tl < bl) && (tr < br);

	logic [SAMPLE_BITS-1:0] absd_top_s2, absd_bot_s2, absd_left_s2, absd_right_s2;
	logic [PROD_W-1:0]      prod_top_s2, prod_bot_s2, prod_left_s2, prod_right_s2;
	logic                   v_inc_s2, v_dec_s2, h_inc_s2, h_dec_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			absd_top_s2   <= absd_top;
			absd_bot_s2   <= absd_bot;
			absd_left_s2  <= absd_left;
			absd_right_s2 <= absd_right;
			prod_top_s2   <= prod_top;
			prod_bot_s2   <= prod_bot;
			prod_left_s2  <= prod_left;
			prod_right_s2 <= prod_right;
			v_inc_s2      <= v_inc;
			v_dec_s2      <= v_dec;
			h_inc_s2      <= h_inc;
			h_dec_s2      <= h_dec;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2 -> result: band compares, flag and pulse update, clamp.
	// ------------------------------------------------------------------
	logic ok_top, ok_bot, ok_left, ok_right;
	logic v_in_band, h_in_band;

	assign ok_top   = CMP_W'({absd_top_s2,   {MARGIN_FRAC_BITS{1'b0}}}) < CMP_W'(prod_top_s2);
	assign ok_bot   = CMP_W'({absd_bot_s2,   {MARGIN_FRAC_BITS{1'b0}}}) < CMP_W'(prod_bot_s2);
	assign ok_left  = CMP_W'({absd_left_s2,  {MARGIN_FRAC_BITS{1'b0}}}) < CMP_W'(prod_left_s2);
	assign ok_right = CMP_W'({absd_right_s2, {MARGIN_FRAC_BITS{1'b0}}}) < CMP_W'(prod_right_s2);

	assign v_in_band = ok_top && ok_bot;
	assign h_in_band = ok_left && ok_right;

	logic [PULSE_W-1:0] v_pulse_q, h_pulse_q;
	logic               v_done_q, h_done_q;
	logic [PULSE_W-1:0] v_pulse_nx, h_pulse_nx;
	logic               v_done_nx, h_done_nx, aligned_nx;
	axis_cmd_t          v_cmd, h_cmd;

	// An axis inside its band holds still; otherwise step toward the light.
	assign v_cmd.up   = !v_in_band && v_inc_s2;
	assign v_cmd.down = !v_in_band && v_dec_s2;
	assign h_cmd.up   = !h_in_band && h_inc_s2;
	assign h_cmd.down = !h_in_band && h_dec_s2;

	sts_axis_step u_vert (
		.pulse      (v_pulse_q),
		.step       (step_q),
		.cmd        (v_cmd),
		.pulse_min  (pulse_min_q),
		.pulse_max  (pulse_max_q),
		.pulse_next (v_pulse_nx)
	);

	sts_axis_step u_horz (
		.pulse      (h_pulse_q),
		.step       (step_q),
		.cmd        (h_cmd),
		.pulse_min  (pulse_min_q),
		.pulse_max  (pulse_max_q),
		.pulse_next (h_pulse_nx)
	);

	// Flags are sticky until both are set; then report aligned and drop both.
	assign v_done_nx  = v_done_q || v_in_band;
	assign h_done_nx  = h_done_q || h_in_band;
	assign aligned_nx = v_done_nx && h_done_nx;

	logic    advance;
	result_t result_q;

	assign advance = valid_s2 && en_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_pulse_q      <= PULSE_RESET;
			h_pulse_q      <= PULSE_RESET;
			v_done_q       <= 1'b0;
			h_done_q       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (en_out) begin
				result_valid_q <= valid_s2;
			end
			if (advance) begin
				v_pulse_q <= v_pulse_nx;
				h_pulse_q <= h_pulse_nx;
				v_done_q  <= v_done_nx && !aligned_nx;
				h_done_q  <= h_done_nx && !aligned_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.horizontal_pulse_us <= h_pulse_nx;
			result_q.vertical_pulse_us   <= v_pulse_nx;
			result_q.aligned             <= aligned_nx;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef NO_ASSERTIONS
	// Both flags set together are always folded into an aligned word.
	a_flags_never_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_done_q && h_done_q))
		else $error("both reached flags held at once");

	// Input is refused only when every stage holds a word and output is stalled.
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> (valid_s1 && valid_s2 && result_valid_q && !result_ready))
		else $error("input stalled with room in the pipeline");

	// A reported aligned word leaves both flags clear.
	a_aligned_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && aligned_nx) |=> (!v_done_q && !h_done_q))
		else $error("flags survived an aligned word");

	// With sane limits the stored pulses stay inside them.
	a_pulse_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (pulse_min_q <= pulse_max_q)) |->
		(v_pulse_nx >= pulse_min_q && v_pulse_nx <= pulse_max_q &&
		 h_pulse_nx >= pulse_min_q && h_pulse_nx <= pulse_max_q))
		else $error("pulse width left the configured limits");
`endif

endmodule
